// ----- src/hri_pkg.sv -----
// Shared types, constants and lookup functions for the Halton radical inverse block.
// Used by hri_ctrl, hri_datapath and halton_radical_inverse; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package hri_pkg;

    // Default values for the top-level parameters.
    localparam int INDEX_BITS_DEF = 24;

    // Highest number of dimensions that the block produces.
    localparam int MAX_DIMS = 8;

    // Field and register widths.
    localparam int COORD_BITS    = 32;
    localparam int DIM_BITS      = 3;
    localparam int NUM_DIMS_BITS = 4;
    localparam logic [NUM_DIMS_BITS-1:0] NUM_DIMS_RESET = 4'd2;

    // Prime bases fit in five bits.
    localparam int PRIME_BITS = 5;

    // Reciprocal multipliers are ceil(2^29 / p); exact floor division for
    // any dividend below 2^24.
    localparam int RECIP_BITS  = 29;
    localparam int RECIP_SHIFT = 29;

    // The largest digit scale p^k for a 24-bit index is 13^7, below 2^26.
    localparam int SCALE_BITS = 26;

    // The final division yields four quotient bits per cycle.
    localparam int DIV_BITS_PER_CYCLE = 4;
    localparam int DIV_CYCLES         = COORD_BITS / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_BITS       = $clog2(DIV_CYCLES);

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIGITS,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load_index;
        logic                start_dim;
        logic                digit_step;
        logic                div_start;
        logic                div_step;
        logic                emit;
        logic [DIM_BITS-1:0] dim;
        logic                last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_zero;
        logic b_pending;
    } status_t;

    // Prime base of each dimension.
    function automatic logic [PRIME_BITS-1:0] prime_of(input logic [DIM_BITS-1:0] dim);
        logic [PRIME_BITS-1:0] p;
        unique case (dim)
            3'd0:    p = 5'd2;
            3'd1:    p = 5'd3;
            3'd2:    p = 5'd5;
            3'd3:    p = 5'd7;
            3'd4:    p = 5'd11;
            3'd5:    p = 5'd13;
            3'd6:    p = 5'd17;
            3'd7:    p = 5'd19;
            default: p = 5'd2;
        endcase
        return p;
    endfunction

    // Reciprocal multiplier ceil(2^29 / p) of each dimension's prime.
    function automatic logic [RECIP_BITS-1:0] recip_of(input logic [DIM_BITS-1:0] dim);
        logic [RECIP_BITS-1:0] m;
        unique case (dim)
            3'd0:    m = 29'd268435456;
            3'd1:    m = 29'd178956971;
            3'd2:    m = 29'd107374183;
            3'd3:    m = 29'd76695845;
            3'd4:    m = 29'd48806447;
            3'd5:    m = 29'd41297763;
            3'd6:    m = 29'd31580642;
            3'd7:    m = 29'd28256364;
            default: m = 29'd268435456;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- src/halton_radical_inverse.sv -----
// Top level of the Halton radical inverse block: controller plus datapath.
// Depends on hri_pkg, hri_ctrl and hri_datapath.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-------------------------------
//  cfg     | in        | cfg_we               | cfg_wdata (num_dims)
//  in      | in        | in_valid / in_stall  | sample_index
//  out     | out       | out_valid / out_stall| coordinate, dim_index, last
//
// One item yields num_dims results. Each dimension extracts the digits of the
// index in that prime base (one digit per cycle from the reciprocal multiplier)
// and then runs the four-bit-per-cycle divider. An index of zero has no digits.
// Reset clears the controller and sets num_dims to 2. A stalled result holds the
// controller in its emit state until the output register frees; a new item is
// accepted while the last result still waits.
`timescale 1ns / 1ps
`default_nettype none

module halton_radical_inverse
    import hri_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [NUM_DIMS_BITS-1:0] cfg_wdata,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [INDEX_BITS-1:0]    sample_index,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [COORD_BITS-1:0]         coordinate,
    output logic [DIM_BITS-1:0]           dim_index,
    output logic                          last
);

    cmd_t    cmd;
    status_t status;

    // Sequencing of dimensions, digits and division.
    hri_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and the output register.
    hri_datapath #(
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample_index (sample_index),
        .coordinate   (coordinate),
        .dim_index    (dim_index),
        .last         (last)
    );

endmodule

`default_nettype wire

// ----- src/hri_ctrl.sv -----
// Controller state machine of the Halton radical inverse block.
// Sequences digit extraction, division and result hand-off; uses hri_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hri_ctrl
    import hri_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [NUM_DIMS_BITS-1:0] cfg_wdata,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    input  wire status_t                  status,
    output cmd_t                          cmd
);

    state_t                   state_reg, state_next;
    logic [DIM_BITS-1:0]      dim_reg, dim_next;
    logic [DIM_BITS-1:0]      last_dim_reg, last_dim_next;
    logic [DIV_CNT_BITS-1:0]  div_cnt_reg, div_cnt_next;
    logic [NUM_DIMS_BITS-1:0] num_dims_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [NUM_DIMS_BITS-1:0] eff_dims;

    // Dimension count clamped to the supported range.
    always_comb
    begin
        if (num_dims_reg == '0)
        begin
            eff_dims = NUM_DIMS_BITS'(1);
        end
        else if (num_dims_reg > NUM_DIMS_BITS'(MAX_DIMS))
        begin
            eff_dims = NUM_DIMS_BITS'(MAX_DIMS);
        end
        else
        begin
            eff_dims = num_dims_reg;
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg <= NUM_DIMS_RESET;
        end
        else if (cfg_we)
        begin
            num_dims_reg <= cfg_wdata;
        end
    end

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dim_reg       <= '0;
            last_dim_reg  <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dim_reg       <= dim_next;
            last_dim_reg  <= last_dim_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next    = state_reg;
        dim_next      = dim_reg;
        last_dim_next = last_dim_reg;
        div_cnt_next  = div_cnt_reg;
        cmd           = '0;
        cmd.dim       = dim_reg;
        cmd.last      = (dim_reg == last_dim_reg);
        in_stall      = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_index = 1'b1;
                    dim_next       = '0;
                    last_dim_next  = DIM_BITS'(eff_dims - NUM_DIMS_BITS'(1));
                    state_next     = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                // Digits are done once the index is zero and no digit is in flight.
                if (status.n_zero && !status.b_pending)
                begin
                    cmd.div_start = 1'b1;
                    div_cnt_next  = '0;
                    state_next    = ST_DIVIDE;
                end
                else
                begin
                    cmd.digit_step = 1'b1;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == DIV_CNT_BITS'(DIV_CYCLES - 1))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + DIV_CNT_BITS'(1);
                end
            end
            ST_EMIT:
            begin
                // The output register takes a new item once the old one is gone.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit = 1'b1;
                    if (dim_reg == last_dim_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        dim_next      = dim_reg + DIM_BITS'(1);
                        cmd.start_dim = 1'b1;
                        state_next    = ST_DIGITS;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag.
    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- src/hri_datapath.sv -----
// Datapath of the Halton radical inverse block: digit extraction by
// reciprocal multiplication, a radix-16 divider and the output register; uses hri_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hri_datapath
    import hri_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    input  wire logic [INDEX_BITS-1:0] sample_index,
    output logic [COORD_BITS-1:0]      coordinate,
    output logic [DIM_BITS-1:0]        dim_index,
    output logic                       last
);

    logic [INDEX_BITS-1:0] index_reg, index_next;
    logic [INDEX_BITS-1:0] n_reg, n_next;
    logic [INDEX_BITS-1:0] nprev_reg, nprev_next;
    logic                  b_pending_reg, b_pending_next;
    logic [SCALE_BITS-1:0] rev_reg, rev_next;
    logic [SCALE_BITS-1:0] scale_reg, scale_next;
    logic [SCALE_BITS-1:0] rem_reg, rem_next;
    logic [COORD_BITS-1:0] quot_reg, quot_next;
    logic [COORD_BITS-1:0] coordinate_reg, coordinate_next;
    logic [DIM_BITS-1:0]   dim_index_reg, dim_index_next;
    logic                  last_reg, last_next;

    logic [PRIME_BITS-1:0]            prime;
    logic [RECIP_BITS-1:0]            recip;
    logic [INDEX_BITS+RECIP_BITS-1:0] recip_prod;
    logic [INDEX_BITS-1:0]            quotient;
    logic [INDEX_BITS+PRIME_BITS-1:0] q_times_p;
    logic [INDEX_BITS-1:0]            digit_full;
    logic [PRIME_BITS-1:0]            digit;
    logic [SCALE_BITS+PRIME_BITS-1:0] rev_times_p;
    logic [SCALE_BITS+PRIME_BITS-1:0] scale_times_p;
    logic [SCALE_BITS:0]              div_wide;
    logic [SCALE_BITS-1:0]            div_rem;
    logic [COORD_BITS-1:0]            div_quot;

    assign prime = prime_of(cmd.dim);
    assign recip = recip_of(cmd.dim);

    // First stage: next index n / p by reciprocal multiplication.
    assign recip_prod = {{RECIP_BITS{1'b0}}, n_reg} * {{INDEX_BITS{1'b0}}, recip};
    assign quotient   = recip_prod[RECIP_SHIFT +: INDEX_BITS];

    // Second stage: the digit as the remainder, folded into the reversed value.
    assign q_times_p     = {{PRIME_BITS{1'b0}}, n_reg} * {{INDEX_BITS{1'b0}}, prime};
    assign digit_full    = nprev_reg - q_times_p[INDEX_BITS-1:0];
    assign digit         = digit_full[PRIME_BITS-1:0];
    assign rev_times_p   = {{PRIME_BITS{1'b0}}, rev_reg} * {{SCALE_BITS{1'b0}}, prime};
    assign scale_times_p = {{PRIME_BITS{1'b0}}, scale_reg} * {{SCALE_BITS{1'b0}}, prime};

    // Restoring division step: several quotient bits of rev * 2^32 / scale.
    always_comb
    begin
        div_rem  = rem_reg;
        div_quot = quot_reg;
        div_wide = '0;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++)
        begin
            div_wide = {div_rem, 1'b0};
            if (div_wide >= {1'b0, scale_reg})
            begin
                div_wide = div_wide - {1'b0, scale_reg};
                div_quot = {div_quot[COORD_BITS-2:0], 1'b1};
            end
            else
            begin
                div_quot = {div_quot[COORD_BITS-2:0], 1'b0};
            end
            div_rem = div_wide[SCALE_BITS-1:0];
        end
    end

    // Next values of all datapath registers.
    always_comb
    begin
        index_next      = index_reg;
        n_next          = n_reg;
        nprev_next      = nprev_reg;
        b_pending_next  = b_pending_reg;
        rev_next        = rev_reg;
        scale_next      = scale_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        coordinate_next = coordinate_reg;
        dim_index_next  = dim_index_reg;
        last_next       = last_reg;

        if (cmd.load_index)
        begin
            index_next     = sample_index;
            n_next         = sample_index;
            rev_next       = '0;
            scale_next     = SCALE_BITS'(1);
            b_pending_next = 1'b0;
        end

        if (cmd.start_dim)
        begin
            n_next         = index_reg;
            rev_next       = '0;
            scale_next     = SCALE_BITS'(1);
            b_pending_next = 1'b0;
        end

        if (cmd.digit_step)
        begin
            if (n_reg != '0)
            begin
                n_next = quotient;
            end
            nprev_next     = n_reg;
            b_pending_next = (n_reg != '0);
            if (b_pending_reg)
            begin
                rev_next   = rev_times_p[SCALE_BITS-1:0] + SCALE_BITS'(digit);
                scale_next = scale_times_p[SCALE_BITS-1:0];
            end
        end

        if (cmd.div_start)
        begin
            rem_next  = rev_reg;
            quot_next = '0;
        end

        if (cmd.div_step)
        begin
            rem_next  = div_rem;
            quot_next = div_quot;
        end

        if (cmd.emit)
        begin
            coordinate_next = quot_reg;
            dim_index_next  = cmd.dim;
            last_next       = cmd.last;
        end
    end

    // Control flag of the digit pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_pending_reg <= 1'b0;
        end
        else
        begin
            b_pending_reg <= b_pending_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        index_reg      <= index_next;
        n_reg          <= n_next;
        nprev_reg      <= nprev_next;
        rev_reg        <= rev_next;
        scale_reg      <= scale_next;
        rem_reg        <= rem_next;
        quot_reg       <= quot_next;
        coordinate_reg <= coordinate_next;
        dim_index_reg  <= dim_index_next;
        last_reg       <= last_next;
    end

    assign status.n_zero    = (n_reg == '0);
    assign status.b_pending = b_pending_reg;

    assign coordinate = coordinate_reg;
    assign dim_index  = dim_index_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the Halton radical inverse block (halton_radical_inverse).
// Predicts every coordinate from the index and the dimension count; depends on hri_pkg.
`timescale 1ns / 1ps

module tb;
    import hri_pkg::*;

    localparam int IDX_W       = INDEX_BITS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 200;
    localparam int MAX_REPORTS = 10;

    // Receiver behaviors for the result channel.
    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_BURSTY,
        RX_HEAVY
    } rx_mode_t;

    // One expected coordinate of a Halton point.
    typedef struct packed {
        logic [COORD_BITS-1:0] coord;
        logic [DIM_BITS-1:0]   dim;
        logic                  last;
    } coord_item_t;

    // Prime base of each dimension, kept independently of the design.
    int unsigned dim_base [MAX_DIMS] = '{2, 3, 5, 7, 11, 13, 17, 19};

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_we;
    logic [NUM_DIMS_BITS-1:0] cfg_wdata;
    logic                     in_valid;
    logic                     in_stall;
    logic [IDX_W-1:0]         sample_index;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [COORD_BITS-1:0]    coordinate;
    logic [DIM_BITS-1:0]      dim_index;
    logic                     last;

    coord_item_t              pending_coords [$];
    logic [NUM_DIMS_BITS-1:0] num_dims_shadow;
    int                       error_count = 0;
    int                       cycle_count = 0;
    rx_mode_t                 stall_mode  = RX_FREE;
    int                       hold_left   = 0;
    int                       stall_run   = 0;
    logic                     stall_level = 1'b0;

    halton_radical_inverse u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_index (sample_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .coordinate   (coordinate),
        .dim_index    (dim_index),
        .last         (last)
    );

    // Free-running clock.
    always #10 clk = ~clk;

    // Run limit in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("halton_radical_inverse verification failed");
            $finish;
        end
    end

    // Exact floor(reversed_digits * 2^32 / base^digits), truncated to 32 bits.
    function automatic logic [COORD_BITS-1:0] coord_in_base(input logic [IDX_W-1:0] n,
                                                           input int unsigned base);
        longint unsigned rem;
        longint unsigned rev;
        longint unsigned scale;
        rem   = 64'(n);
        rev   = 0;
        scale = 1;
        while (rem != 0)
        begin
            rev   = rev * base + (rem % base);
            rem   = rem / base;
            scale = scale * base;
        end
        return COORD_BITS'((rev << 32) / scale);
    endfunction

    // Queue the coordinates that one accepted index must produce.
    task automatic predict_point(input logic [IDX_W-1:0] n);
        int          dims;
        coord_item_t item;
        dims = int'(num_dims_shadow);
        if (dims < 1)
            dims = 1;
        if (dims > MAX_DIMS)
            dims = MAX_DIMS;
        for (int i = 0; i < dims; i++)
        begin
            item.coord = coord_in_base(n, dim_base[i]);
            item.dim   = i[DIM_BITS-1:0];
            item.last  = (i == dims - 1);
            pending_coords = {pending_coords, item};
        end
    endtask

    // Compare each accepted result with the oldest expected coordinate.
    always @(posedge clk)
    begin : check_result
        coord_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_coords.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result: coordinate %h dim %0d last %0d",
                             coordinate, dim_index, last);
            end
            else
            begin
                want = pending_coords.pop_front();
                if (want.coord !== coordinate || want.dim !== dim_index || want.last !== last)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("mismatch: expected coord %h dim %0d last %0d, got %h %0d %0d",
                                 want.coord, want.dim, want.last,
                                 coordinate, dim_index, last);
                end
            end
        end
    end

    // Result-channel stall: a long hold-off when requested, else the current mode.
    always @(negedge clk)
    begin : drive_out_stall
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            case (stall_mode)
                RX_FREE:  out_stall <= 1'b0;
                RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    if (stall_run == 0)
                    begin
                        stall_level = ~stall_level;
                        stall_run   = $urandom_range(1, 8);
                    end
                    stall_run = stall_run - 1;
                    out_stall <= stall_level;
                end
            endcase
        end
    end

    // Offer one index and wait until the block takes it.
    task automatic send_item(input logic [IDX_W-1:0] idx);
        @(negedge clk);
        in_valid     <= 1'b1;
        sample_index <= idx;
        do
            @(posedge clk);
        while (in_stall);
        predict_point(idx);
    endtask

    // Keep the input channel quiet for a number of cycles.
    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // Change the receiver behavior at a rising edge.
    task automatic set_receiver(input rx_mode_t mode);
        idle_cycles(1);
        @(posedge clk);
        stall_mode = mode;
    endtask

    // Ask the receiver to hold off for a fixed number of cycles.
    task automatic hold_receiver(input int n);
        idle_cycles(1);
        @(posedge clk);
        hold_left = n;
    endtask

    // Write the dimension count once every pending coordinate has come out.
    task automatic write_num_dims(input logic [NUM_DIMS_BITS-1:0] value);
        idle_cycles(1);
        while (pending_coords.size() != 0)
            @(posedge clk);
        idle_cycles(20);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        num_dims_shadow = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random index: full width, small, near a prime power, or near the top.
    function automatic logic [IDX_W-1:0] pick_index();
        int unsigned base;
        int unsigned v;
        case ($urandom_range(0, 4))
            0: return IDX_W'($urandom);
            1: return IDX_W'($urandom_range(0, 255));
            2: return IDX_W'($urandom_range(0, 65535));
            3:
            begin
                base = dim_base[$urandom_range(0, MAX_DIMS - 1)];
                v    = 1;
                repeat ($urandom_range(1, 23))
                    if (v * base < (1 << IDX_W))
                        v = v * base;
                v = v + $urandom_range(0, 2);
                v = (v == 0) ? 0 : v - 1;
                if (v >= (1 << IDX_W))
                    v = (1 << IDX_W) - 1;
                return IDX_W'(v);
            end
            default: return IDX_W'({IDX_W{1'b1}} - $urandom_range(0, 15));
        endcase
    endfunction

    // The reset value of the dimension count is two.
    task automatic test_reset_default();
        num_dims_shadow = NUM_DIMS_RESET;
        send_item(24'd5);
        send_item(24'hFFFFFF);
    endtask

    // Index extremes, bit patterns and exact prime powers over all eight bases.
    task automatic test_corner_indexes();
        int unsigned corner_idx [19] = '{
            0, 1, 2, 3, 4, 24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'h555555, 24'hAAAAAA,
            14348907, 14348906, 9765625, 5764801, 1771561, 4826809, 1419857,
            2476099, 2476098
        };
        write_num_dims(4'd8);
        foreach (corner_idx[i])
            send_item(IDX_W'(corner_idx[i]));
    endtask

    // A zero count acts as one, and counts above the maximum saturate.
    task automatic test_dim_count_limits();
        write_num_dims(4'd0);
        send_item(24'd7);
        write_num_dims(4'd9);
        send_item(24'd12345);
        write_num_dims(4'd15);
        send_item(24'hFFFFFF);
        write_num_dims(4'd1);
        send_item(24'd6);
    endtask

    // The receiver holds off while items keep coming, so the block stalls its input.
    task automatic test_backpressure();
        write_num_dims(4'd8);
        set_receiver(RX_FREE);
        hold_receiver(600);
        repeat (24)
            send_item(pick_index());
    endtask

    // Random indexes over several dimension counts and idling patterns.
    task automatic test_random_phases();
        logic [NUM_DIMS_BITS-1:0] dims_list [6] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd5, 4'd3};
        logic [NUM_DIMS_BITS-1:0] dims;
        int                       burst_left;
        for (int ph = 0; ph < 6; ph++)
        begin
            dims = (ph == 5) ? NUM_DIMS_BITS'($urandom_range(0, 15)) : dims_list[ph];
            write_num_dims(dims);
            set_receiver(rx_mode_t'(ph % 4));
            burst_left = 0;
            for (int i = 0; i < 64; i++)
            begin
                // Phases two and four send back to back.
                if (burst_left == 0)
                begin
                    if (ph != 2 && ph != 4)
                        idle_cycles($urandom_range(1, 12));
                    burst_left = $urandom_range(1, 10);
                end
                send_item(pick_index());
                burst_left--;
            end
        end
    endtask

    // Reset, the tests in turn, then drain and report.
    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        sample_index = '0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_default();
        test_corner_indexes();
        test_dim_count_limits();
        test_backpressure();
        test_random_phases();

        set_receiver(RX_FREE);
        while (pending_coords.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);
        if (error_count == 0 && pending_coords.size() == 0)
            $display("halton_radical_inverse verification clean");
        else
            $display("halton_radical_inverse verification failed");
        $finish;
    end

endmodule
